// ===== hdl/ipi_pkg.sv =====
`default_nettype none

package ipi_pkg;

    // Fixed widths of the gain, limit and output words
    localparam int GAIN_W = 24;
    localparam int OUT_W  = 24;
    localparam int CFG_W  = 24;
    localparam int CFG_IDX_W = 3;

    // Saturation range of the output word
    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    // Defaults for the top level parameters
    localparam int SIGNAL_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_CURRENT  = 3'd0,
        CFG_GAIN_PREVIOUS = 3'd1,
        CFG_UPPER_LIMIT   = 3'd2,
        CFG_LOWER_LIMIT   = 3'd3,
        CFG_CLAMP_MODE    = 3'd4
    } t_cfg_idx;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_current;
        logic signed [GAIN_W-1:0] gain_previous;
        logic signed [OUT_W-1:0]  upper_limit;
        logic signed [OUT_W-1:0]  lower_limit;
        logic                     clamp_mode;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/ipi_cfg.sv =====
`default_nettype none

module ipi_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ipi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ipi_pkg::CFG_W-1:0]     i_cfg_wdata,
    output ipi_pkg::t_cfg                      o_cfg
);
    import ipi_pkg::*;

    t_cfg r_cfg;

    // Register file; writes to unused indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_current  <= '0;
            r_cfg.gain_previous <= '0;
            r_cfg.upper_limit   <= OUT_W'(OUT_MAX);
            r_cfg.lower_limit   <= OUT_W'(OUT_MIN);
            r_cfg.clamp_mode    <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_CURRENT:  r_cfg.gain_current  <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_GAIN_PREVIOUS: r_cfg.gain_previous <= $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_UPPER_LIMIT:   r_cfg.upper_limit   <= $signed(i_cfg_wdata[OUT_W-1:0]);
                CFG_LOWER_LIMIT:   r_cfg.lower_limit   <= $signed(i_cfg_wdata[OUT_W-1:0]);
                CFG_CLAMP_MODE:    r_cfg.clamp_mode    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/ipi_core.sv =====
`default_nettype none

module ipi_core #(
    parameter int SIGNAL_WIDTH   = ipi_pkg::SIGNAL_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ipi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire ipi_pkg::t_cfg                  i_cfg,
    input  wire logic                           i_enable,
    input  wire logic signed [SIGNAL_WIDTH-1:0] i_setpoint,
    input  wire logic signed [SIGNAL_WIDTH-1:0] i_feedback,
    input  wire logic signed [SIGNAL_WIDTH-1:0] i_feedforward,
    input  wire logic signed [SIGNAL_WIDTH:0]   i_prev_err,
    input  wire logic signed [SIGNAL_WIDTH-1:0] i_prev_ff,
    input  wire logic signed [ipi_pkg::OUT_W-1:0] i_acc,
    output logic signed [SIGNAL_WIDTH:0]        o_err_next,
    output logic signed [SIGNAL_WIDTH-1:0]      o_ff_next,
    output logic signed [ipi_pkg::OUT_W-1:0]    o_acc_next,
    output logic                                o_clamped
);
    import ipi_pkg::*;

    localparam int ERR_W  = SIGNAL_WIDTH + 1;
    localparam int PROD_W = GAIN_W + ERR_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int Y_W    = SUM_W + 2;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic signed [Y_W-1:0]   Y_MAX = Y_W'(OUT_MAX);
    localparam logic signed [Y_W-1:0]   Y_MIN = Y_W'(OUT_MIN);

    logic signed [ERR_W-1:0]  w_err;
    logic signed [PROD_W-1:0] w_prod_cur;
    logic signed [PROD_W-1:0] w_prod_prev;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_inc;
    logic signed [Y_W-1:0]    w_y;
    logic signed [Y_W-1:0]    w_upper;
    logic signed [Y_W-1:0]    w_lower;
    logic signed [Y_W-1:0]    w_sat;
    logic signed [Y_W-1:0]    w_lim;
    logic                     w_sat_hit;
    logic                     w_lim_hit;

    // Error and the two gain products
    assign w_err       = ERR_W'(i_setpoint) - ERR_W'(i_feedback);
    assign w_prod_cur  = PROD_W'(i_cfg.gain_current) * PROD_W'(w_err);
    assign w_prod_prev = PROD_W'(i_cfg.gain_previous) * PROD_W'(i_prev_err);

    // Round half up to the output grid
    assign w_sum = SUM_W'(w_prod_cur) + SUM_W'(w_prod_prev) + ROUND_BIAS;
    assign w_inc = w_sum >>> GAIN_FRAC_BITS;

    // New output before limiting
    assign w_y = Y_W'(i_acc) + Y_W'(w_inc) + Y_W'(i_feedforward) - Y_W'(i_prev_ff);

    assign w_upper = Y_W'(i_cfg.upper_limit);
    assign w_lower = Y_W'(i_cfg.lower_limit);

    // Range saturation, then limits (upper tested first)
    always_comb begin
        w_sat     = w_y;
        w_sat_hit = 1'b0;
        if (w_y > Y_MAX) begin
            w_sat     = Y_MAX;
            w_sat_hit = 1'b1;
        end else if (w_y < Y_MIN) begin
            w_sat     = Y_MIN;
            w_sat_hit = 1'b1;
        end
        w_lim     = w_sat;
        w_lim_hit = 1'b0;
        if (i_cfg.clamp_mode) begin
            if (w_sat > w_upper) begin
                w_lim     = w_upper;
                w_lim_hit = 1'b1;
            end else if (w_sat < w_lower) begin
                w_lim     = w_lower;
                w_lim_hit = 1'b1;
            end
        end
    end

    // Disabled sample clears history and output
    always_comb begin
        if (i_enable) begin
            o_err_next = w_err;
            o_ff_next  = i_feedforward;
            o_acc_next = w_lim[OUT_W-1:0];
            o_clamped  = w_sat_hit | w_lim_hit;
        end else begin
            o_err_next = '0;
            o_ff_next  = '0;
            o_acc_next = '0;
            o_clamped  = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/incremental_pi_controller.sv =====
`default_nettype none

// Channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// sample   | i_valid / o_ready    | i_enable, i_setpoint, i_feedback, i_feedforward
// result   | o_valid / i_ready    | o_control_out, o_clamped
// config   | i_cfg_we             | i_cfg_idx, i_cfg_wdata
//
// One sample per cycle sustained while i_ready is high; an accepted sample goes
// into the sample register, then into the result register, where it can be taken.
// The regulator math is combinational between the sample register and the
// result register, which also updates the error/feedforward/output history.
// Synchronous active-low reset clears history and handshake state and resets config to defaults.
// A stalled result holds the sample register; input stalls only when both are full.

module incremental_pi_controller #(
    parameter int SIGNAL_WIDTH   = ipi_pkg::SIGNAL_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ipi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_enable,
    input  wire logic signed [SIGNAL_WIDTH-1:0] i_setpoint,
    input  wire logic signed [SIGNAL_WIDTH-1:0] i_feedback,
    input  wire logic signed [SIGNAL_WIDTH-1:0] i_feedforward,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [ipi_pkg::OUT_W-1:0]    o_control_out,
    output logic                                o_clamped,
    input  wire logic                           i_cfg_we,
    input  wire logic [ipi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ipi_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import ipi_pkg::*;

    t_cfg w_cfg;

    // Sample register
    logic                           r_in_valid;
    logic                           r_in_enable;
    logic signed [SIGNAL_WIDTH-1:0] r_in_setpoint;
    logic signed [SIGNAL_WIDTH-1:0] r_in_feedback;
    logic signed [SIGNAL_WIDTH-1:0] r_in_feedforward;

    // Regulator history
    logic signed [SIGNAL_WIDTH:0]   r_prev_err;
    logic signed [SIGNAL_WIDTH-1:0] r_prev_ff;
    logic signed [OUT_W-1:0]        r_acc;

    // Result register
    logic                           r_out_valid;
    logic signed [OUT_W-1:0]        r_out_y;
    logic                           r_out_clamped;

    logic signed [SIGNAL_WIDTH:0]   n_prev_err;
    logic signed [SIGNAL_WIDTH-1:0] n_prev_ff;
    logic signed [OUT_W-1:0]        n_acc;
    logic                           n_clamped;
    logic                           w_advance;

    ipi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ipi_core #(
        .SIGNAL_WIDTH   (SIGNAL_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .i_cfg         (w_cfg),
        .i_enable      (r_in_enable),
        .i_setpoint    (r_in_setpoint),
        .i_feedback    (r_in_feedback),
        .i_feedforward (r_in_feedforward),
        .i_prev_err    (r_prev_err),
        .i_prev_ff     (r_prev_ff),
        .i_acc         (r_acc),
        .o_err_next    (n_prev_err),
        .o_ff_next     (n_prev_ff),
        .o_acc_next    (n_acc),
        .o_clamped     (n_clamped)
    );

    // Sample moves to the result register when that slot is free or draining
    assign w_advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready   = ~r_in_valid | w_advance;

    // Sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_enable      <= i_enable;
            r_in_setpoint    <= i_setpoint;
            r_in_feedback    <= i_feedback;
            r_in_feedforward <= i_feedforward;
        end
    end

    // History and result update together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err  <= '0;
            r_prev_ff   <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_prev_err <= n_prev_err;
                r_prev_ff  <= n_prev_ff;
                r_acc      <= n_acc;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_y       <= n_acc;
            r_out_clamped <= n_clamped;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_control_out = r_out_y;
    assign o_clamped     = r_out_clamped;

    // A shown result always matches the held output
    a_out_matches_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_y == r_acc))
        else $error("result differs from held output");

    // A disabled request yields zero output, no clamp flag and cleared error/feedforward history
    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_in_enable) |=> (r_out_y == '0 && !r_out_clamped
            && r_prev_err == '0 && r_prev_ff == '0))
        else $error("disabled request did not clear state");

    // A waiting sample is never dropped
    a_sample_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("pending sample lost");

    // An advancing sample always produces a result
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded");

endmodule

`default_nettype wire
